// ===== sv/mfb_pkg.sv =====
`default_nettype none
package mfb_pkg;

  localparam int DEF_COLUMNS = 132;
  localparam int DEF_ROWS    = 32;
  localparam int DEF_PAGES   = 4;

  localparam logic [2:0] REQ_SET_PIXEL   = 3'd0;
  localparam logic [2:0] REQ_CLEAR_PIXEL = 3'd1;
  localparam logic [2:0] REQ_CLEAR_STORE = 3'd2;
  localparam logic [2:0] REQ_REFRESH     = 3'd3;
  localparam logic [2:0] REQ_INIT        = 3'd4;

  localparam int INIT_LEN = 14;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hb0;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] FILL_ONES     = 8'hff;
  localparam logic [7:0] FILL_ZEROS    = 8'h00;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  function automatic logic [7:0] init_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h40;
      4'd1:    b = 8'ha1;
      4'd2:    b = 8'hc0;
      4'd3:    b = 8'ha6;
      4'd4:    b = 8'ha2;
      4'd5:    b = 8'h2f;
      4'd6:    b = 8'hf8;
      4'd7:    b = 8'h00;
      4'd8:    b = 8'h23;
      4'd9:    b = 8'h81;
      4'd10:   b = 8'h1f;
      4'd11:   b = 8'hac;
      4'd12:   b = 8'h00;
      4'd13:   b = 8'haf;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== sv/mfb_store.sv =====
`default_nettype none
module mfb_store #(
  parameter int DEPTH  = 528,
  parameter int ADDR_W = 10
) (
  input  wire              clk,
  input  mfb_pkg::mem_ctl_t ctl,
  input  wire [ADDR_W-1:0] addr,
  input  wire [7:0]        wdata,
  output logic [7:0]       rdata
);
  import mfb_pkg::*;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
    if (ctl.re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/mfb_ctrl.sv =====
`default_nettype none
module mfb_ctrl #(
  parameter int COLUMNS = 132,
  parameter int ROWS    = 32,
  parameter int PAGES   = 4,
  parameter int DEPTH   = 528,
  parameter int ADDR_W  = 10
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_we,
  input  wire               cfg_wdata,
  input  wire               s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire [15:0]        s_axis_tdata,
  input  wire [2:0]         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire               m_axis_tready,
  output logic [7:0]        m_axis_tdata,
  output logic              m_axis_tuser,
  output logic              m_axis_tlast,
  output mfb_pkg::mem_ctl_t mem_ctl,
  output logic [ADDR_W-1:0] mem_addr,
  output logic [7:0]        mem_wdata,
  input  wire [7:0]         mem_rdata
);
  import mfb_pkg::*;

  localparam int PG_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int POS_W = $clog2(COLUMNS + 3);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_PIXEL   = 3'd1;
  localparam logic [2:0] ST_CLEAR   = 3'd2;
  localparam logic [2:0] ST_REFRESH = 3'd3;
  localparam logic [2:0] ST_INIT    = 3'd4;

  logic [2:0]        state;
  logic              invert;
  logic [ADDR_W-1:0] sweep;
  logic [7:0]        fill;
  logic              then_init;
  logic [3:0]        init_idx;
  logic [PG_W-1:0]   pg;
  logic [POS_W-1:0]  pos;
  logic [ADDR_W-1:0] ref_addr;
  logic [ADDR_W-1:0] pix_addr;
  logic [7:0]        pix_mask;
  logic              pix_on;
  logic [7:0]        pend_byte;
  logic              pend_data;
  logic              pend_last;

  logic [7:0]        x;
  logic [5:0]        y;
  logic [2:0]        req;
  logic              accept;
  logic              in_panel;
  logic [ADDR_W-1:0] in_addr;
  logic              slot_free;
  logic              ref_is_data;
  logic              out_load;

  assign x   = s_axis_tdata[7:0];
  assign y   = s_axis_tdata[13:8];
  assign req = s_axis_tuser;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_panel      = ({1'b0, x} < 9'(COLUMNS)) && ({1'b0, y} < 7'(ROWS))
                         && ({1'b0, y[5:3]} < 4'(PAGES));
  assign in_addr       = ADDR_W'(ADDR_W'(y[5:3]) * ADDR_W'(COLUMNS) + ADDR_W'(x));
  assign slot_free     = !m_axis_tvalid || m_axis_tready;
  assign ref_is_data   = (pos > POS_W'(2));
  assign out_load      = ((state == ST_REFRESH) || (state == ST_INIT)) && slot_free;

  always_comb begin
    mem_ctl   = '0;
    mem_addr  = sweep;
    mem_wdata = fill;
    case (state)
      ST_IDLE: begin
        if (accept && (req == REQ_SET_PIXEL || req == REQ_CLEAR_PIXEL) && in_panel) begin
          mem_ctl.re = 1'b1;
          mem_addr   = in_addr;
        end else if (accept && req == REQ_REFRESH && ref_is_data) begin
          mem_ctl.re = 1'b1;
          mem_addr   = ref_addr;
        end
      end
      ST_PIXEL: begin
        mem_ctl.we = 1'b1;
        mem_addr   = pix_addr;
        mem_wdata  = pix_on ? (mem_rdata | pix_mask) : (mem_rdata & ~pix_mask);
      end
      ST_CLEAR: begin
        mem_ctl.we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      invert        <= 1'b0;
      sweep         <= '0;
      fill          <= FILL_ZEROS;
      then_init     <= 1'b0;
      init_idx      <= '0;
      pg            <= '0;
      pos           <= '0;
      ref_addr      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        invert <= cfg_wdata;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req)
              REQ_SET_PIXEL, REQ_CLEAR_PIXEL: begin
                if (in_panel) begin
                  state    <= ST_PIXEL;
                  pix_addr <= in_addr;
                  pix_mask <= 8'(1 << y[2:0]);
                  pix_on   <= (req == REQ_SET_PIXEL) ^ invert;
                end
              end
              REQ_CLEAR_STORE, REQ_INIT: begin
                state     <= ST_CLEAR;
                sweep     <= '0;
                fill      <= invert ? FILL_ONES : FILL_ZEROS;
                then_init <= (req == REQ_INIT);
                init_idx  <= '0;
                if (req == REQ_INIT) begin
                  pg       <= '0;
                  pos      <= '0;
                  ref_addr <= '0;
                end
              end
              REQ_REFRESH: begin
                state     <= ST_REFRESH;
                pend_data <= ref_is_data;
                pend_last <= (pg == PG_W'(PAGES - 1)) && (pos == POS_W'(COLUMNS + 2));
                if (pos == POS_W'(0)) begin
                  pend_byte <= CMD_PAGE_BASE + 8'(pg);
                end else if (pos == POS_W'(1)) begin
                  pend_byte <= CMD_COL_HIGH;
                end else begin
                  pend_byte <= CMD_COL_LOW;
                end
                if (ref_is_data) begin
                  ref_addr <= ref_addr + 1'b1;
                end
                if (pos == POS_W'(COLUMNS + 2)) begin
                  pos <= '0;
                  if (pg == PG_W'(PAGES - 1)) begin
                    pg       <= '0;
                    ref_addr <= '0;
                  end else begin
                    pg <= pg + 1'b1;
                  end
                end else begin
                  pos <= pos + 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_PIXEL: begin
          state <= ST_IDLE;
        end
        ST_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == ADDR_W'(DEPTH - 1)) begin
            state <= then_init ? ST_INIT : ST_IDLE;
          end
        end
        ST_REFRESH: begin
          if (slot_free) begin
            m_axis_tdata <= pend_data ? mem_rdata : pend_byte;
            m_axis_tuser <= pend_data;
            m_axis_tlast <= pend_last;
            state        <= ST_IDLE;
          end
        end
        ST_INIT: begin
          if (slot_free) begin
            m_axis_tdata <= init_byte(init_idx);
            m_axis_tuser <= 1'b0;
            m_axis_tlast <= (init_idx == 4'(INIT_LEN - 1));
            init_idx     <= init_idx + 1'b1;
            if (init_idx == 4'(INIT_LEN - 1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/paged_mono_framebuffer_refresher.sv =====
// channel     dir   tdata                      tuser          tlast
// s_axis      in    x [7:0], y [13:8]          req_type       -
// m_axis      out   out_byte [7:0]             is_data        last
// cfg         in    cfg_wdata = invert         -              -
//
// set / clear pixel: a read and a write-back on the frame store; off panel, no store access
// refresh tick: one store read for a data byte, then the byte enters the output register
// clear store: one store entry written per cycle, over all PAGES*COLUMNS entries
// init: the clear sweep, then 14 command bytes, one per cycle the output register frees
// reset (rst, synchronous): a clearing pass over all PAGES*COLUMNS entries, no requests taken
// a stalled m_axis holds refresh and init; pixel requests go through until one of those waits
`default_nettype none
module paged_mono_framebuffer_refresher #(
  parameter int COLUMNS = mfb_pkg::DEF_COLUMNS,
  parameter int ROWS    = mfb_pkg::DEF_ROWS,
  parameter int PAGES   = mfb_pkg::DEF_PAGES
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire        cfg_wdata,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [15:0] s_axis_tdata,  // x [7:0], y [13:8], zero [15:14]
  input  wire [2:0]  s_axis_tuser,  // req_type [2:0]
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata,  // out_byte [7:0]
  output logic       m_axis_tuser,  // is_data [0]
  output logic       m_axis_tlast
);
  import mfb_pkg::*;

  localparam int DEPTH  = PAGES * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);

  mem_ctl_t          mem_ctl;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;

  mfb_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .PAGES   (PAGES),
    .DEPTH   (DEPTH),
    .ADDR_W  (ADDR_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .mem_ctl       (mem_ctl),
    .mem_addr      (mem_addr),
    .mem_wdata     (mem_wdata),
    .mem_rdata     (mem_rdata)
  );

  mfb_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire
